FILE: rtl/core/scm_pkg.sv
// Shared types, constants and codes of the shadow memory access checker.
`timescale 1ns / 1ps
package scm_pkg;

	// Shadow store geometry: one shadow byte per 8-byte granule.
	localparam int SHADOW_ENTRIES = 4096;
	localparam int IDX_W          = $clog2(SHADOW_ENTRIES);
	localparam int ADDR_W         = 32;
	localparam int LEN_W          = 16;
	localparam int SHADOW_W       = 8;
	localparam int GRAN_W         = 3;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;

	// Command codes.
	typedef enum logic [1:0] {
		CMD_CHECK = 2'd0,
		CMD_FILL  = 2'd1,
		CMD_ALLOC = 2'd2,
		CMD_NONE  = 2'd3
	} scm_cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STS_DONE     = 2'd0,
		STS_DISABLED = 2'd1,
		STS_RANGE    = 2'd2,
		STS_RSVD     = 2'd3
	} scm_status_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE = 2'd0,
		REG_BASE   = 2'd1,
		REG_LIMIT  = 2'd2,
		REG_NONE   = 2'd3
	} scm_reg_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} scm_state_t;

	// Write port of the shadow RAM.
	typedef struct packed {
		logic                en;
		logic [IDX_W-1:0]    addr;
		logic [SHADOW_W-1:0] data;
	} scm_wr_t;

	// Read port of the shadow RAM.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} scm_rd_t;

endpackage

FILE: rtl/core/scm_if.sv
// Handshake channel interfaces for commands, results and configuration writes.
`timescale 1ns / 1ps

// Command channel.
interface scm_req_if import scm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        cmd;
	logic [ADDR_W-1:0] address;
	logic [LEN_W-1:0]  length;
	logic [7:0]        fill_value;

	modport source (output valid, cmd, address, length, fill_value, input ready);
	modport sink   (input valid, cmd, address, length, fill_value, output ready);
endinterface

// Result channel.
interface scm_rsp_if ();
	logic       valid;
	logic       ready;
	logic       fault;
	logic [1:0] status;

	modport source (output valid, fault, status, input ready);
	modport sink   (input valid, fault, status, output ready);
endinterface

// Configuration write channel.
interface scm_cfg_if import scm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/scm_shadow_ram.sv
// Shadow byte store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module scm_shadow_ram import scm_pkg::*; (
	input  logic                clk,
	input  scm_wr_t             wr,
	input  scm_rd_t             rd,
	output logic [SHADOW_W-1:0] rd_data
);

	logic [SHADOW_W-1:0] mem [SHADOW_ENTRIES];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read port, with registered read data.
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

FILE: rtl/core/shadow_memory_access_checker.sv
// Top level of the shadow memory access checker: sequencer, registers and result stage.
`timescale 1ns / 1ps
// Usage:
// The req channel carries one command per transaction: check an access, fill
// aligned granules with a shadow value, or mark an allocation. The rsp channel
// returns one transaction per command with fault and status. The cfg channel
// writes checking_enabled, region_base and region_limit; it is always ready. The
// user must write it only while no command is in flight; the block does not check.
// Flow: a command passes through the decode, walk, drain and finish states and
// walks the shadow granules it touches, one granule per cycle through the single
// read or write port of the shadow RAM; a command rejected up front goes from decode to finish.
// The result is loaded into the output register from the finish state.
// Typical accesses of up to 16 bytes span at most three granules.
// Reset: arst_n clears the registers, then a clearing pass writes zero into all
// 4096 shadow entries, one per cycle; req.ready stays low until the pass is done.
// Stall: the result sits in an output register, so the next command is taken
// while a result waits; a command that finishes while that register is still
// full holds in its last state until rsp.ready frees it.
module shadow_memory_access_checker import scm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	scm_cfg_if.sink   cfg,
	scm_req_if.sink   req,
	scm_rsp_if.source rsp
);

	scm_state_t state_q, state_d;

	// Configuration registers.
	logic              enable_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] limit_q;

	// Registered command.
	scm_cmd_t          cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic [7:0]        val_q;

	// Walk state.
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       first_q;
	logic [IDX_W-1:0]       last_q;
	logic [GRAN_W-1:0]      rlo_q;
	logic [GRAN_W-1:0]      rhi_q;
	logic [GRAN_W-1:0]      boff_q;
	logic [LEN_W-GRAN_W-1:0] zero_left_q;
	logic                   fault_q;
	scm_status_t            status_q;

	// Read pipeline stage.
	logic rd_vld_s1;
	logic first_s1;
	logic last_s1;

	// Output register.
	logic        out_vld_q;
	logic        out_fault_q;
	scm_status_t out_status_q;

	scm_wr_t             wr;
	scm_rd_t             rd;
	logic [SHADOW_W-1:0] rd_data;

	scm_shadow_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	// Range arithmetic on the registered command.
	logic [ADDR_W:0]   end_ext;
	logic [ADDR_W-1:0] rel_first;
	logic [ADDR_W-1:0] rel_end;
	logic              wraps;
	logic              in_base;
	logic              span_fit;
	logic              span_ok;

	assign end_ext   = {1'b0, addr_q} + (ADDR_W+1)'(len_q) - (ADDR_W+1)'(1);
	assign wraps     = end_ext[ADDR_W];
	assign rel_first = addr_q - base_q;
	assign rel_end   = end_ext[ADDR_W-1:0] - base_q;
	assign in_base   = addr_q >= base_q;
	assign span_fit  = {{GRAN_W{1'b0}}, rel_end[ADDR_W-1:GRAN_W]} < ADDR_W'(SHADOW_ENTRIES);
	assign span_ok   = in_base && !wraps && span_fit;

	// Up-front decision per command.
	logic        dec_walk;
	logic        dec_fault;
	scm_status_t dec_status;

	always_comb begin
		dec_walk   = 1'b0;
		dec_fault  = 1'b0;
		dec_status = STS_DONE;
		if (cmd_q == CMD_NONE) begin
			dec_status = STS_DONE;
		end else if (!enable_q) begin
			dec_status = STS_DISABLED;
		end else begin
			case (cmd_q)
				CMD_CHECK: begin
					if (len_q == '0 || !in_base || addr_q >= limit_q) begin
						dec_status = STS_DONE;
					end else if (wraps) begin
						dec_fault = 1'b1;
					end else if (!span_fit) begin
						dec_status = STS_RANGE;
					end else begin
						dec_walk = 1'b1;
					end
				end
				CMD_FILL: begin
					if (addr_q[GRAN_W-1:0] != '0 || len_q[GRAN_W-1:0] != '0) begin
						dec_status = STS_RANGE;
					end else if (len_q == '0) begin
						dec_status = STS_DONE;
					end else if (!span_ok) begin
						dec_status = STS_RANGE;
					end else begin
						dec_walk = 1'b1;
					end
				end
				default: begin
					if (len_q[LEN_W-1:GRAN_W] != '0 && addr_q[GRAN_W-1:0] != '0) begin
						dec_status = STS_RANGE;
					end else if (len_q == '0) begin
						dec_status = STS_DONE;
					end else if (!span_ok) begin
						dec_status = STS_RANGE;
					end else begin
						dec_walk = 1'b1;
					end
				end
			endcase
		end
	end

	// Granule test on the shadow byte read in the previous cycle. The byte offset
	// is taken from the absolute address, so the base offset is added back in.
	logic [GRAN_W-1:0] r_lo;
	logic [GRAN_W-1:0] r_hi;
	logic [GRAN_W:0]   sum_lo;
	logic [GRAN_W:0]   sum_hi;
	logic [GRAN_W-1:0] max_off;
	logic              gran_bad;

	always_comb begin
		r_lo    = first_s1 ? rlo_q : '0;
		r_hi    = last_s1 ? rhi_q : '1;
		sum_lo  = {1'b0, r_lo} + {1'b0, boff_q};
		sum_hi  = {1'b0, r_hi} + {1'b0, boff_q};
		max_off = (sum_hi[GRAN_W] && !sum_lo[GRAN_W]) ? '1 : sum_hi[GRAN_W-1:0];
		gran_bad = (rd_data != '0) &&
			((rd_data >= SHADOW_W'(8)) || (SHADOW_W'(max_off) >= rd_data));
	end

	// Next state and RAM port control.
	logic out_load;

	always_comb begin
		state_d  = state_q;
		wr       = '0;
		rd.en    = 1'b0;
		rd.addr  = idx_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				wr.en   = 1'b1;
				wr.addr = idx_q;
				wr.data = '0;
				if (idx_q == IDX_W'(SHADOW_ENTRIES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = dec_walk ? ST_WALK : ST_FINISH;
			end
			ST_WALK: begin
				case (cmd_q)
					CMD_CHECK: begin
						rd.en = 1'b1;
					end
					CMD_FILL: begin
						wr.en   = 1'b1;
						wr.addr = idx_q;
						wr.data = val_q;
					end
					default: begin
						wr.addr = idx_q;
						if (len_q[GRAN_W-1:0] != '0 && idx_q == last_q) begin
							wr.en   = 1'b1;
							wr.data = SHADOW_W'(len_q[GRAN_W-1:0]);
						end else if (zero_left_q != '0) begin
							wr.en   = 1'b1;
							wr.data = '0;
						end
					end
				endcase
				if (idx_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_vld_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			base_q   <= '0;
			limit_q  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_ENABLE: enable_q <= cfg.data[0];
				REG_BASE:   base_q   <= cfg.data[ADDR_W-1:0];
				REG_LIMIT:  limit_q  <= cfg.data[ADDR_W-1:0];
				default:    ;
			endcase
		end
	end

	// Entry counter, shared by the clearing pass and the walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (state_q == ST_CLEAR || state_q == ST_WALK) begin
			idx_q <= idx_q + IDX_W'(1);
		end else if (state_q == ST_DECODE) begin
			idx_q <= rel_first[GRAN_W +: IDX_W];
		end
	end

	// Command capture and walk bounds.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			cmd_q  <= scm_cmd_t'(req.cmd);
			addr_q <= req.address;
			len_q  <= req.length;
			val_q  <= req.fill_value;
		end
		if (state_q == ST_DECODE) begin
			first_q     <= rel_first[GRAN_W +: IDX_W];
			last_q      <= rel_end[GRAN_W +: IDX_W];
			rlo_q       <= rel_first[GRAN_W-1:0];
			rhi_q       <= rel_end[GRAN_W-1:0];
			boff_q      <= base_q[GRAN_W-1:0];
			zero_left_q <= len_q[LEN_W-1:GRAN_W];
			status_q    <= dec_status;
		end else if (state_q == ST_WALK && zero_left_q != '0) begin
			zero_left_q <= zero_left_q - (LEN_W-GRAN_W)'(1);
		end
		if (rd.en) begin
			first_s1 <= idx_q == first_q;
			last_s1  <= idx_q == last_q;
		end
	end

	// Fault accumulation over the granules read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			fault_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= rd.en;
			if (state_q == ST_DECODE) begin
				fault_q <= dec_fault;
			end else if (rd_vld_s1 && gran_bad) begin
				fault_q <= 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_fault_q  <= fault_q;
			out_status_q <= status_q;
		end
	end

	assign req.ready  = state_q == ST_IDLE;
	assign cfg.ready  = 1'b1;
	assign rsp.valid  = out_vld_q;
	assign rsp.fault  = out_fault_q;
	assign rsp.status = out_status_q;

	// A result is loaded only from the finishing state.
	a_load_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> state_q == ST_FINISH)
		else $error("result loaded outside the finishing state");

	// The walk never runs past the last granule of the command.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> idx_q <= last_q && idx_q >= first_q)
		else $error("walk index outside the command's granules");

	// A check command never writes the shadow store.
	a_check_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && cmd_q == CMD_CHECK) |-> !wr.en)
		else $error("shadow store written during a check");

	// Disabled checking never reports a fault.
	a_disabled_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STS_DISABLED) |-> !rsp.fault)
		else $error("fault reported with checking disabled");

endmodule

FILE: bench/shadow_result_checker.sv
// Predictor and scoreboard that watch the channels of the shadow memory access checker.
`timescale 1ns / 1ps
module shadow_result_checker import scm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	scm_cfg_if   cfg,
	scm_req_if   req,
	scm_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding
);

	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic        fault;
		scm_status_t status;
	} shadow_result_t;

	// Own copy of the shadow bytes and of the three registers.
	logic [SHADOW_W-1:0] shadow_mem [SHADOW_ENTRIES];
	logic                model_enable;
	logic [ADDR_W-1:0]   model_base;
	logic [ADDR_W-1:0]   model_limit;

	shadow_result_t expected_results [$];
	int             result_count;

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_REPORTS)
			$display("ERROR: result %0d: %s", result_count, msg);
		mismatches++;
	endtask

	// Shadow index range of a nonempty byte range; false when it cannot be stored.
	function automatic bit span_in_store(input longint unsigned addr, input longint unsigned len,
		output longint unsigned first_idx, output longint unsigned last_idx);
		longint unsigned last_byte;
		last_byte = addr + len - 1;
		first_idx = 0;
		last_idx  = 0;
		if (addr < model_base || last_byte > 64'hFFFF_FFFF)
			return 1'b0;
		first_idx = (addr - model_base) >> 3;
		last_idx  = (last_byte - model_base) >> 3;
		return last_idx < SHADOW_ENTRIES;
	endfunction

	// A byte is reachable when its granule is clear or the partial count covers its offset.
	function automatic bit byte_accessible(input longint unsigned a);
		logic [SHADOW_W-1:0] s;
		s = shadow_mem[(a - model_base) >> 3];
		if (s == 8'd0)
			return 1'b1;
		if (s >= 8'd8)
			return 1'b0;
		return (a & 64'h7) < s;
	endfunction

	// Applies one command to the shadow copy and returns the result it must produce.
	function automatic shadow_result_t run_command(input scm_cmd_t op, input logic [31:0] addr_in,
		input logic [15:0] len_in, input logic [7:0] value);
		shadow_result_t  res;
		longint unsigned addr, len, first_idx, last_idx, whole, k;
		addr       = addr_in;
		len        = len_in;
		res.fault  = 1'b0;
		res.status = STS_DONE;
		if (op == CMD_NONE)
			return res;
		if (!model_enable) begin
			res.status = STS_DISABLED;
			return res;
		end
		case (op)
			CMD_CHECK: begin
				// Only the first byte is tested against the region bounds.
				if (len != 0 && addr >= model_base && addr < model_limit) begin
					if (addr + len > 64'h1_0000_0000) begin
						res.fault = 1'b1;
					end else if (!span_in_store(addr, len, first_idx, last_idx)) begin
						res.status = STS_RANGE;
					end else begin
						for (k = 0; k < len; k++) begin
							if (!byte_accessible(addr + k)) begin
								res.fault = 1'b1;
								break;
							end
						end
					end
				end
			end
			CMD_FILL: begin
				if (addr_in[2:0] != 3'd0 || len_in[2:0] != 3'd0) begin
					res.status = STS_RANGE;
				end else if (len != 0) begin
					if (!span_in_store(addr, len, first_idx, last_idx))
						res.status = STS_RANGE;
					else
						for (k = first_idx; k <= last_idx; k++)
							shadow_mem[k] = value;
				end
			end
			CMD_ALLOC: begin
				// Whole granules are cleared, a trailing partial granule gets its byte count.
				whole = len & ~64'h7;
				if (whole != 0 && addr_in[2:0] != 3'd0) begin
					res.status = STS_RANGE;
				end else if (len != 0) begin
					if (!span_in_store(addr, len, first_idx, last_idx)) begin
						res.status = STS_RANGE;
					end else begin
						for (k = first_idx; k < first_idx + (whole >> 3); k++)
							shadow_mem[k] = 8'd0;
						if (len_in[2:0] != 3'd0)
							shadow_mem[last_idx] = {5'd0, len_in[2:0]};
					end
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Register writes, command predictions and result comparison, all at the clock edge.
	always @(posedge clk or negedge arst_n) begin
		shadow_result_t exp_res;
		if (!arst_n) begin
			for (int i = 0; i < SHADOW_ENTRIES; i++)
				shadow_mem[i] = 8'd0;
			model_enable = 1'b0;
			model_base   = '0;
			model_limit  = '0;
			expected_results.delete();
			result_count = 0;
			mismatches   = 0;
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (scm_reg_t'(cfg.index))
					REG_ENABLE: model_enable = cfg.data[0];
					REG_BASE:   model_base   = cfg.data;
					REG_LIMIT:  model_limit  = cfg.data;
					default: begin
					end
				endcase
			end
			if (req.valid && req.ready)
				expected_results.push_back(run_command(scm_cmd_t'(req.cmd), req.address,
					req.length, req.fill_value));
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result transaction with no command waiting");
				end else begin
					exp_res = expected_results.pop_front();
					if (rsp.fault !== exp_res.fault)
						report_mismatch($sformatf("fault expected %0d got %0d",
							exp_res.fault, rsp.fault));
					if (rsp.status !== exp_res.status)
						report_mismatch($sformatf("status expected %0d got %0d",
							exp_res.status, rsp.status));
				end
				result_count++;
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
// Testbench top: clock, reset, stimulus, idling and verdict for the shadow memory access checker.
`timescale 1ns / 1ps
module tb_top;
	import scm_pkg::*;

	localparam int          WATCHDOG_LIMIT  = 20000;
	localparam int          RSP_HOLD_CYCLES = 300;
	localparam logic [31:0] DIR_BASE        = 32'h1000_0000;
	localparam logic [31:0] STORE_BYTES     = SHADOW_ENTRIES * 8;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   tx_gap_pct;
	int   rx_stall_pct;
	int   hold_rsp;
	int   idle_cycles;

	scm_cfg_if cfg_ch ();
	scm_req_if req_ch ();
	scm_rsp_if rsp_ch ();

	shadow_memory_access_checker u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	shadow_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_ch),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int pick_gap(input int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// Offers one command and returns at the falling edge after it was taken.
	task automatic send_cmd(input scm_cmd_t op, input logic [31:0] addr, input logic [15:0] len,
		input logic [7:0] value);
		int gap;
		gap = pick_gap(tx_gap_pct);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= op;
		req_ch.address    <= addr;
		req_ch.length     <= len;
		req_ch.fill_value <= value;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Stops offering commands until every outstanding result has come back.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input scm_reg_t idx, input logic [31:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	// Registers change only while the block is idle.
	task automatic set_regs(input logic enable, input logic [31:0] base, input logic [31:0] limit);
		wait_drained();
		write_reg(REG_ENABLE, {31'd0, enable});
		write_reg(REG_BASE, base);
		write_reg(REG_LIMIT, limit);
		cfg_ch.valid <= 1'b0;
	endtask

	// One random command, mostly well formed and aimed at a small window of the region.
	task automatic random_cmd(input logic [31:0] win_lo, input int win_span);
		int          pick;
		int          p;
		int          v;
		scm_cmd_t    op;
		logic [31:0] addr;
		logic [15:0] len;
		logic [7:0]  value;
		pick  = $urandom_range(0, 99);
		p     = $urandom_range(0, 99);
		addr  = win_lo + $urandom_range(0, win_span - 1);
		len   = 16'($urandom_range(0, 65535));
		value = 8'($urandom_range(0, 255));
		if (pick < 4) begin
			op   = scm_cmd_t'($urandom_range(0, 3));
			addr = $urandom;
		end else if (pick < 7) begin
			op = CMD_NONE;
		end else if (pick < 55) begin
			op = CMD_CHECK;
			if (p < 5)
				len = 16'd0;
			else if (p < 90)
				len = 16'($urandom_range(1, 16));
			else if (p < 98)
				len = 16'($urandom_range(17, 96));
		end else if (pick < 78) begin
			op = CMD_FILL;
			if (p < 90) begin
				addr[2:0] = 3'd0;
				len       = 16'(8 * $urandom_range(0, 8));
			end else if (p < 98) begin
				len = 16'($urandom_range(0, 70));
			end else begin
				addr[2:0] = 3'd0;
				len       = 16'(8 * $urandom_range(0, 4095));
			end
			// Clear, partial and fully poisoned granules in roughly equal share.
			v = $urandom_range(0, 9);
			if (v < 4)
				value = 8'd0;
			else if (v < 7)
				value = 8'($urandom_range(1, 7));
		end else begin
			op = CMD_ALLOC;
			if (p < 85)
				addr[2:0] = 3'd0;
			if (p < 98)
				len = 16'($urandom_range(0, 70));
		end
		send_cmd(op, addr, len, value);
	endtask

	// One setting of the registers with its share of random commands.
	task automatic run_phase(input logic enable, input logic [31:0] base, input logic [31:0] limit,
		input logic [31:0] win_lo, input int win_span, input int count, input int tx_pct,
		input int rx_pct, input int pause_at, input int hold_at);
		set_regs(enable, base, limit);
		tx_gap_pct   = tx_pct;
		rx_stall_pct = rx_pct;
		for (int i = 0; i < count; i++) begin
			if (i == pause_at)
				wait_drained();
			if (i == hold_at)
				hold_rsp++;
			random_cmd(win_lo, win_span);
		end
	endtask

	// Result side: random stalls, and one long hold-off each time one is asked for.
	initial begin
		int stall_left;
		int stall;
		int holds_done;
		stall_left   = 0;
		holds_done   = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rsp != holds_done) begin
				rsp_ch.ready <= 1'b0;
				holds_done = hold_rsp;
				repeat (RSP_HOLD_CYCLES) @(negedge clk);
				rsp_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				stall = pick_gap(rx_stall_pct);
				if (stall > 0) begin
					rsp_ch.ready <= 1'b0;
					stall_left = stall - 1;
				end else begin
					rsp_ch.ready <= 1'b1;
				end
			end
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL shadow_memory_access_checker");
			$finish;
		end
	end

	// Stimulus and verdict.
	initial begin
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.cmd        = CMD_CHECK;
		req_ch.address    = '0;
		req_ch.length     = '0;
		req_ch.fill_value = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = REG_ENABLE;
		cfg_ch.data       = '0;
		tx_gap_pct        = 20;
		rx_stall_pct      = 20;
		hold_rsp          = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Registers still at reset: checking is off, the unused command does nothing.
		send_cmd(CMD_CHECK, 32'h0, 16'd4, 8'h00);
		send_cmd(CMD_FILL, 32'h0, 16'd8, 8'hFF);
		send_cmd(CMD_ALLOC, 32'h0, 16'd8, 8'h00);
		send_cmd(CMD_NONE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);

		// Region wider than the shadow store, so the store end can be crossed.
		set_regs(1'b1, DIR_BASE, DIR_BASE + STORE_BYTES + 32'd64);
		send_cmd(CMD_CHECK, DIR_BASE, 16'd0, 8'h00);
		send_cmd(CMD_CHECK, 32'h0, 16'd16, 8'h00);
		send_cmd(CMD_CHECK, 32'hFFFF_FFFF, 16'd1, 8'h00);
		send_cmd(CMD_CHECK, DIR_BASE, 16'd16, 8'h00);
		send_cmd(CMD_FILL, DIR_BASE, 16'd32, 8'hFF);
		send_cmd(CMD_CHECK, DIR_BASE + 32'd3, 16'd4, 8'h00);
		send_cmd(CMD_FILL, DIR_BASE + 32'd4, 16'd8, 8'h00);
		send_cmd(CMD_FILL, DIR_BASE, 16'd12, 8'h00);
		send_cmd(CMD_FILL, DIR_BASE, 16'd0, 8'h00);
		// A partial granule of five bytes after one whole granule.
		send_cmd(CMD_ALLOC, DIR_BASE, 16'd13, 8'h00);
		send_cmd(CMD_CHECK, DIR_BASE + 32'd8, 16'd5, 8'h00);
		send_cmd(CMD_CHECK, DIR_BASE + 32'd8, 16'd6, 8'h00);
		send_cmd(CMD_ALLOC, DIR_BASE + 32'd19, 16'd9, 8'h00);
		send_cmd(CMD_ALLOC, DIR_BASE + 32'd19, 16'd3, 8'h00);
		// A shadow value of eight or more poisons the whole granule.
		send_cmd(CMD_FILL, DIR_BASE + 32'd24, 16'd8, 8'h08);
		send_cmd(CMD_CHECK, DIR_BASE + 32'd24, 16'd1, 8'h00);
		send_cmd(CMD_CHECK, DIR_BASE + STORE_BYTES - 32'd8, 16'd16, 8'h00);
		send_cmd(CMD_FILL, DIR_BASE - 32'd8, 16'd8, 8'h01);
		send_cmd(CMD_ALLOC, DIR_BASE + STORE_BYTES, 16'd8, 8'h00);
		send_cmd(CMD_CHECK, DIR_BASE, 16'hFFFF, 8'h00);

		// Region at the top of the address space: accesses that wrap.
		set_regs(1'b1, 32'hFFFF_8000, 32'hFFFF_FFFF);
		send_cmd(CMD_CHECK, 32'hFFFF_FFF8, 16'd16, 8'h00);
		send_cmd(CMD_FILL, 32'hFFFF_FFF8, 16'd16, 8'h00);

		// Random phases under different register settings and idling.
		begin
			logic [31:0] base;
			base = $urandom_range(0, 32'h7FFF_0000) & ~32'h7;
			run_phase(1'b1, base, base + 32'd33000, base, 512, 280, 30, 30, 140, -1);
			base = $urandom_range(32'h100, 32'hFFF0_0000);
			run_phase(1'b1, base, base + $urandom_range(64, 600), base - 32'd32, 700, 200,
				25, 25, -1, 50);
			run_phase(1'b1, 32'h0, 32'hFFFF_FFFF, 32'h0, 512, 200, 0, 0, -1, -1);
			run_phase(1'b1, 32'hFFFF_8000, 32'hFFFF_FFFF, 32'hFFFF_FE00, 512, 200,
				50, 50, -1, -1);
			run_phase(1'b0, $urandom, 32'h0, 32'h0, 512, 60, 30, 30, -1, -1);
			run_phase(1'b1, 32'h0000_1000, 32'h0000_0800, 32'h0000_1000, 512, 80,
				30, 30, -1, -1);
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("PASS shadow_memory_access_checker");
		else
			$display("FAIL shadow_memory_access_checker");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/scm_pkg.sv
rtl/core/scm_if.sv
rtl/core/scm_shadow_ram.sv
rtl/core/shadow_memory_access_checker.sv
bench/shadow_result_checker.sv
bench/tb_top.sv
